FILE: rtl/dibs_pkg.sv
// ----------------------------------------------------------------------------
// Digest index splitter package
// Shared types, register indexes, reset values and helper functions for the
// digest index bit splitter.
// ----------------------------------------------------------------------------
package dibs_pkg;

   // Default values of the top-level parameters.
   localparam int MAX_DIGITS_DEF = 64;
   localparam int VALUE_BITS_DEF = 64;

   // Fixed widths of the payload and configuration fields.
   localparam int BYTE_W     = 8;
   localparam int AVAIL_W    = 4;
   localparam int VALUE_W    = 64;
   localparam int DNUM_W     = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_NUM_DIGITS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DIGIT_BITS      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TREE_INDEX_BITS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LEAF_INDEX_BITS = 3'd3;

   // Register reset values before clamping.
   localparam logic [6:0] NUM_DIGITS_RST      = 7'd14;
   localparam logic [5:0] DIGIT_BITS_RST      = 6'd12;
   localparam logic [6:0] TREE_INDEX_BITS_RST = 7'd54;
   localparam logic [5:0] LEAF_INDEX_BITS_RST = 6'd9;

   // Widest digit and leaf index.
   localparam logic [6:0] MAX_FIELD_BITS = 7'd32;

   // Parse phase of the digest.
   typedef enum logic [1:0] {
      PH_DIGITS = 2'd0,
      PH_TREE   = 2'd1,
      PH_LEAF   = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   // Kind of an extracted field.
   typedef enum logic [1:0] {
      KIND_DIGIT = 2'd0,
      KIND_TREE  = 2'd1,
      KIND_LEAF  = 2'd2
   } kind_type;

   // Input beat.
   typedef struct packed {
      logic [BYTE_W-1:0] byte_in;
      logic              restart;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      kind_type           kind;
      logic [DNUM_W-1:0]  digit_number;
      logic               end_of_run;
      logic               last_of_digest;
   } rsp_type;

   // Clamped configuration as seen by the datapath.
   typedef struct packed {
      logic [6:0] num_digits;
      logic [5:0] digit_bits;
      logic [6:0] tree_index_bits;
      logic [5:0] leaf_index_bits;
   } cfg_type;

   // Status of one slicing step.
   typedef struct packed {
      logic emit;
      logic more;
   } step_ctrl_type;

   // Saturate a register value to a closed range.
   function automatic logic [6:0] clamp7(input logic [6:0] v, input logic [6:0] lo,
                                         input logic [6:0] hi);
      logic [6:0] r;
      r = v;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end
      return r;
   endfunction

endpackage

FILE: rtl/dibs_cfg.sv
// ----------------------------------------------------------------------------
// Digest index splitter configuration registers
// Holds the four field-width registers, saturated to their legal ranges when
// written, and flags every write so the parse position can be cleared.
// ----------------------------------------------------------------------------
module dibs_cfg #(
   parameter int MAX_DIGITS = dibs_pkg::MAX_DIGITS_DEF,
   parameter int VALUE_BITS = dibs_pkg::VALUE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dibs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dibs_pkg::CSR_DATA_W-1:0] csr_data,
   output dibs_pkg::cfg_type               cfg,
   output logic                            cfg_write
);
   import dibs_pkg::*;

   logic [6:0] num_digits_ff,      num_digits_in;
   logic [5:0] digit_bits_ff,      digit_bits_in;
   logic [6:0] tree_index_bits_ff, tree_index_bits_in;
   logic [5:0] leaf_index_bits_ff, leaf_index_bits_in;

   // The port takes a write in every cycle.
   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid && csr_ready;

   // Decode the index and saturate the written value.
   always_comb begin
      num_digits_in      = num_digits_ff;
      digit_bits_in      = digit_bits_ff;
      tree_index_bits_in = tree_index_bits_ff;
      leaf_index_bits_in = leaf_index_bits_ff;
      if (cfg_write) begin
         unique case (csr_index)
            REG_NUM_DIGITS: begin
               num_digits_in = clamp7(csr_data, 7'd1, 7'(MAX_DIGITS));
            end
            REG_DIGIT_BITS: begin
               digit_bits_in = 6'(clamp7({1'b0, csr_data[5:0]}, 7'd1, MAX_FIELD_BITS));
            end
            REG_TREE_INDEX_BITS: begin
               tree_index_bits_in = clamp7(csr_data, 7'd0, 7'(VALUE_BITS));
            end
            REG_LEAF_INDEX_BITS: begin
               leaf_index_bits_in = 6'(clamp7({1'b0, csr_data[5:0]}, 7'd1, MAX_FIELD_BITS));
            end
            default: begin
               // Indexes beyond the register list only clear the parse.
            end
         endcase
      end
   end

   // Register file with saturated reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_digits_ff      <= clamp7(NUM_DIGITS_RST, 7'd1, 7'(MAX_DIGITS));
         digit_bits_ff      <= 6'(clamp7({1'b0, DIGIT_BITS_RST}, 7'd1, MAX_FIELD_BITS));
         tree_index_bits_ff <= clamp7(TREE_INDEX_BITS_RST, 7'd0, 7'(VALUE_BITS));
         leaf_index_bits_ff <= 6'(clamp7({1'b0, LEAF_INDEX_BITS_RST}, 7'd1, MAX_FIELD_BITS));
      end else begin
         num_digits_ff      <= num_digits_in;
         digit_bits_ff      <= digit_bits_in;
         tree_index_bits_ff <= tree_index_bits_in;
         leaf_index_bits_ff <= leaf_index_bits_in;
      end
   end

   assign cfg.num_digits      = num_digits_ff;
   assign cfg.digit_bits      = digit_bits_ff;
   assign cfg.tree_index_bits = tree_index_bits_ff;
   assign cfg.leaf_index_bits = leaf_index_bits_ff;

endmodule

FILE: rtl/dibs_slice.sv
// ----------------------------------------------------------------------------
// Digest index splitter slicing step
// Takes the unread bits of the current byte and the parse state, pulls out the
// bits the current field still needs and produces at most one result per step.
// ----------------------------------------------------------------------------
module dibs_slice #(
   parameter  int MAX_DIGITS = dibs_pkg::MAX_DIGITS_DEF,
   parameter  int VALUE_BITS = dibs_pkg::VALUE_BITS_DEF,
   localparam int COLL_W     = $clog2(VALUE_BITS + 1),
   localparam int DCNT_W     = $clog2(MAX_DIGITS + 1)
) (
   input  dibs_pkg::cfg_type                cfg,
   input  dibs_pkg::phase_type              phase_i,
   input  logic [VALUE_BITS-1:0]            acc_i,
   input  logic [COLL_W-1:0]                coll_i,
   input  logic [DCNT_W-1:0]                dcount_i,
   input  logic [dibs_pkg::BYTE_W-1:0]      byte_i,
   input  logic [dibs_pkg::AVAIL_W-1:0]     avail_i,
   output dibs_pkg::phase_type              phase_o,
   output logic [VALUE_BITS-1:0]            acc_o,
   output logic [COLL_W-1:0]                coll_o,
   output logic [DCNT_W-1:0]                dcount_o,
   output logic [dibs_pkg::AVAIL_W-1:0]     avail_o,
   output dibs_pkg::rsp_type                result,
   output dibs_pkg::step_ctrl_type          ctrl
);
   import dibs_pkg::*;

   logic [6:0]            width;
   logic [6:0]            need;
   logic [AVAIL_W-1:0]    take;
   logic [AVAIL_W-1:0]    avail1;
   logic [BYTE_W-1:0]     shifted;
   logic [BYTE_W-1:0]     chunk;
   logic [BYTE_W-1:0]     tail;
   logic [COLL_W-1:0]     coll1;
   logic                  complete;
   logic                  last_digit;
   logic                  more_digits;
   logic                  tree_zero;
   logic [VALUE_BITS-1:0] acc_dig;
   logic [VALUE_BITS-1:0] acc_shf;

   // Width of the field being collected in this phase.
   always_comb begin
      unique case (phase_i)
         PH_DIGITS: width = {1'b0, cfg.digit_bits};
         PH_TREE:   width = cfg.tree_index_bits;
         PH_LEAF:   width = {1'b0, cfg.leaf_index_bits};
         PH_DONE:   width = 7'd0;
      endcase
   end

   // Take as many top bits of the unread part as the field still needs.
   assign need     = width - 7'(coll_i);
   assign take     = (need < 7'(avail_i)) ? AVAIL_W'(need) : avail_i;
   assign shifted  = byte_i >> (avail_i - take);
   assign chunk    = shifted & ~(8'hFF << take);
   assign avail1   = avail_i - take;
   assign coll1    = coll_i + COLL_W'(take);
   assign complete = (7'(take) == need);

   // Digits grow upward from their first chunk; indexes shift in at the bottom.
   assign acc_dig = acc_i | (VALUE_BITS'(chunk) << coll_i);
   assign acc_shf = (acc_i << take) | VALUE_BITS'(chunk);

   // Bits left over after a digit, and what they lead to.
   assign tail        = byte_i & ~(8'hFF << avail1);
   assign last_digit  = (7'(dcount_i) + 7'd1) >= cfg.num_digits;
   assign more_digits = {2'b00, avail1} >= cfg.digit_bits;
   assign tree_zero   = (cfg.tree_index_bits == 7'd0);

   // One step of the parse.
   always_comb begin
      phase_o               = phase_i;
      acc_o                 = acc_i;
      coll_o                = coll_i;
      dcount_o              = dcount_i;
      avail_o               = '0;
      ctrl                  = '0;
      result.value          = '0;
      result.kind           = KIND_DIGIT;
      result.digit_number   = '0;
      result.last_of_digest = 1'b0;
      unique case (phase_i)
         PH_DIGITS: begin
            if (complete) begin
               ctrl.emit           = 1'b1;
               result.value        = VALUE_W'(acc_dig);
               result.digit_number = DNUM_W'(dcount_i);
               dcount_o            = dcount_i + DCNT_W'(1);
               if (last_digit) begin
                  // The rest of the byte is skipped; a zero-width tree index
                  // follows as a result of its own.
                  phase_o   = PH_TREE;
                  acc_o     = '0;
                  coll_o    = '0;
                  ctrl.more = tree_zero;
               end else if (more_digits) begin
                  acc_o     = '0;
                  coll_o    = '0;
                  avail_o   = avail1;
                  ctrl.more = 1'b1;
               end else begin
                  // Leftover bits start the next digit.
                  acc_o  = VALUE_BITS'(tail);
                  coll_o = COLL_W'(avail1);
               end
            end else begin
               acc_o  = acc_dig;
               coll_o = coll1;
            end
         end
         PH_TREE: begin
            if (complete) begin
               ctrl.emit    = 1'b1;
               result.value = VALUE_W'(acc_shf);
               result.kind  = KIND_TREE;
               phase_o      = PH_LEAF;
               acc_o        = '0;
               coll_o       = '0;
            end else begin
               acc_o  = acc_shf;
               coll_o = coll1;
            end
         end
         PH_LEAF: begin
            if (complete) begin
               ctrl.emit             = 1'b1;
               result.value          = VALUE_W'(acc_shf);
               result.kind           = KIND_LEAF;
               result.last_of_digest = 1'b1;
               phase_o               = PH_DONE;
               acc_o                 = '0;
               coll_o                = '0;
            end else begin
               acc_o  = acc_shf;
               coll_o = coll1;
            end
         end
         PH_DONE: begin
            // Bytes after the leaf index are dropped.
         end
      endcase
      result.end_of_run = ctrl.emit && !ctrl.more;
   end

endmodule

FILE: rtl/digest_index_bit_splitter_top.sv
// ----------------------------------------------------------------------------
// Digest index bit splitter
// Splits a message-digest byte stream into FORS digits, a tree index and a
// leaf index.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one digest byte per beat; restart marks the first
//   byte of a new digest. The rsp_ channel carries one extracted field per
//   beat, with end_of_run on the last field a byte produced and
//   last_of_digest on the leaf index. Bytes that complete no field give no
//   result beat. The csr_ port writes the four width registers; any write
//   also clears the parse position. Write it only while the block is idle.
//   A byte stays in the input register until all its results are emitted, as
//   the slicing step emits one field per cycle while the result slot is free;
//   the next byte is taken in the cycle the current one finishes. With digits
//   of eight bits or more that is one byte per cycle while the receiver does
//   not stall, except for the byte that ends the last digit when the tree
//   index has zero width, which gives two results. A result passes the input
//   register and then the result register before it can be taken. Reset
//   restores the register defaults and the parse position and drops any byte
//   or result in flight. When the receiver stalls, the result register holds
//   its beat and req_stall rises once the input register needs the result slot.
// ----------------------------------------------------------------------------
module digest_index_bit_splitter_top #(
   parameter int MAX_DIGITS = dibs_pkg::MAX_DIGITS_DEF,
   parameter int VALUE_BITS = dibs_pkg::VALUE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  dibs_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output dibs_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dibs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dibs_pkg::CSR_DATA_W-1:0] csr_data
);
   import dibs_pkg::*;

   localparam int COLL_W = $clog2(VALUE_BITS + 1);
   localparam int DCNT_W = $clog2(MAX_DIGITS + 1);

   cfg_type               cfg;
   logic                  cfg_write;

   // Input register.
   logic                  item_valid_ff,   item_valid_in;
   logic [BYTE_W-1:0]     item_byte_ff,    item_byte_in;
   logic                  item_restart_ff, item_restart_in;
   logic [AVAIL_W-1:0]    item_avail_ff,   item_avail_in;

   // Parse state.
   phase_type             phase_ff,  phase_in;
   logic [VALUE_BITS-1:0] acc_ff,    acc_in;
   logic [COLL_W-1:0]     coll_ff,   coll_in;
   logic [DCNT_W-1:0]     dcount_ff, dcount_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff,  rsp_data_in;

   // Step inputs and outputs.
   phase_type             eff_phase;
   logic [VALUE_BITS-1:0] eff_acc;
   logic [COLL_W-1:0]     eff_coll;
   logic [DCNT_W-1:0]     eff_dcount;
   phase_type             step_phase;
   logic [VALUE_BITS-1:0] step_acc;
   logic [COLL_W-1:0]     step_coll;
   logic [DCNT_W-1:0]     step_dcount;
   logic [AVAIL_W-1:0]    step_avail;
   rsp_type               step_result;
   step_ctrl_type         step_ctrl;

   logic                  out_free;
   logic                  advance;
   logic                  finish;
   logic                  req_take;

   dibs_cfg #(
      .MAX_DIGITS (MAX_DIGITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .cfg_write (cfg_write)
   );

   // A restart byte works on a cleared parse position.
   assign eff_phase  = item_restart_ff ? PH_DIGITS : phase_ff;
   assign eff_acc    = item_restart_ff ? '0 : acc_ff;
   assign eff_coll   = item_restart_ff ? '0 : coll_ff;
   assign eff_dcount = item_restart_ff ? '0 : dcount_ff;

   dibs_slice #(
      .MAX_DIGITS (MAX_DIGITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_slice (
      .cfg      (cfg),
      .phase_i  (eff_phase),
      .acc_i    (eff_acc),
      .coll_i   (eff_coll),
      .dcount_i (eff_dcount),
      .byte_i   (item_byte_ff),
      .avail_i  (item_avail_ff),
      .phase_o  (step_phase),
      .acc_o    (step_acc),
      .coll_o   (step_coll),
      .dcount_o (step_dcount),
      .avail_o  (step_avail),
      .result   (step_result),
      .ctrl     (step_ctrl)
   );

   // Handshake: a step runs when its result has a free slot.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = item_valid_ff && (!step_ctrl.emit || out_free);
   assign finish    = advance && !step_ctrl.more;
   assign req_stall = item_valid_ff && !finish;
   assign req_take  = req_valid && !req_stall;

   // Input register next values.
   always_comb begin
      item_valid_in   = item_valid_ff;
      item_byte_in    = item_byte_ff;
      item_restart_in = item_restart_ff;
      item_avail_in   = item_avail_ff;
      if (req_take) begin
         item_valid_in   = 1'b1;
         item_byte_in    = req_data.byte_in;
         item_restart_in = req_data.restart;
         item_avail_in   = AVAIL_W'(BYTE_W);
      end else if (advance) begin
         item_valid_in   = !finish;
         item_restart_in = 1'b0;
         item_avail_in   = step_avail;
      end
   end

   // Parse state next values; a register write clears the position.
   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      coll_in   = coll_ff;
      dcount_in = dcount_ff;
      if (cfg_write) begin
         phase_in  = PH_DIGITS;
         acc_in    = '0;
         coll_in   = '0;
         dcount_in = '0;
      end else if (advance) begin
         phase_in  = step_phase;
         acc_in    = step_acc;
         coll_in   = step_coll;
         dcount_in = step_dcount;
      end
   end

   // Result register next values.
   assign rsp_valid_in = (advance && step_ctrl.emit) || (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = (advance && step_ctrl.emit) ? step_result : rsp_data_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff   <= 1'b0;
         item_restart_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         phase_ff        <= PH_DIGITS;
         acc_ff          <= '0;
         coll_ff         <= '0;
         dcount_ff       <= '0;
      end else begin
         item_valid_ff   <= item_valid_in;
         item_restart_ff <= item_restart_in;
         rsp_valid_ff    <= rsp_valid_in;
         phase_ff        <= phase_in;
         acc_ff          <= acc_in;
         coll_ff         <= coll_in;
         dcount_ff       <= dcount_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_byte_ff  <= item_byte_in;
      item_avail_ff <= item_avail_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
